// ===== rtl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// shared types, constants and the arctangent table of the tilt filter
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ATAN_LEN        = 24;
    localparam int ATAN_IDX_W      = 5;
    localparam int ITER_W          = $clog2(CORDIC_STEPS);
    localparam int ROT_W           = 36;
    localparam int Z_W             = ANGLE_FRAC_BITS + 10;
    localparam int EST_W           = 32;
    localparam int MA_W            = 42;
    localparam int MB_W            = 18;
    localparam int PROD_W          = MA_W + MB_W;
    localparam int ESUM_W          = 41;
    localparam int STEP_SH         = 24 - ANGLE_FRAC_BITS;
    localparam int BLEND_SH        = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 24;

    localparam logic [31:0] ATAN_Q24 [ATAN_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
        32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
        32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
        32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
        32'd115
    };

    localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180) <<< ANGLE_FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_OFFSET_X = 2'd0,
        CFG_GYRO_OFFSET_Y = 2'd1,
        CFG_BLEND_WEIGHT  = 2'd2,
        CFG_GYRO_SCALE    = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_RATE,
        PH_SUM,
        PH_GAIN,
        PH_ACCEL,
        PH_BLEND
    } t_phase;

    typedef struct packed {
        logic                  zero;
        logic signed [16:0]    x0;
        logic signed [16:0]    y0;
        logic signed [Z_W-1:0] z0;
    } t_lane;

    typedef struct packed {
        logic signed [15:0] g_x;
        logic signed [15:0] g_y;
        t_lane              lane_x;
        t_lane              lane_y;
    } t_work;

    typedef struct packed {
        logic [10:0] pulse_x;
        logic [10:0] pulse_y;
        logic [7:0]  angle_x;
        logic [7:0]  angle_y;
    } t_result;

    function automatic logic signed [Z_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] r;
        r = 32'd0;
        if (idx < ATAN_IDX_W'(ATAN_LEN)) begin
            r = (ATAN_Q24[idx] + (32'd1 << (23 - ANGLE_FRAC_BITS))) >> STEP_SH;
        end
        return $signed(r[Z_W-1:0]);
    endfunction

endpackage

// ===== rtl/tcf_front.sv =====
// ----------------------------------------------------------------------------
// tcf_front
// removes gyro bias and folds the accelerometer vectors into the right half plane
// ----------------------------------------------------------------------------
module tcf_front (
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    output tcf_pkg::t_work     o_work
);
    import tcf_pkg::*;

    function automatic t_lane prep(input logic signed [15:0] y, input logic signed [15:0] x);
        t_lane l;
        l.zero = (x == 16'sd0) && (y == 16'sd0);
        l.x0   = {x[15], x};
        l.y0   = {y[15], y};
        l.z0   = '0;
        if (x[15]) begin
            l.x0 = -l.x0;
            l.y0 = -l.y0;
            l.z0 = y[15] ? -HALF_TURN : HALF_TURN;
        end
        return l;
    endfunction

    always_comb begin
        o_work.g_x    = i_rate_x - i_offset_x;
        o_work.g_y    = i_rate_y - i_offset_y;
        o_work.lane_x = prep(i_accel_y, i_accel_z);
        o_work.lane_y = prep(i_accel_x, i_accel_z);
    end

endmodule

// ===== rtl/tcf_queue.sv =====
// ----------------------------------------------------------------------------
// tcf_queue
// two-entry word queue between the front and the back
// ----------------------------------------------------------------------------
module tcf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  tcf_pkg::t_work i_wr_data,
    output logic           o_full,
    input  logic           i_rd,
    output tcf_pkg::t_work o_rd_data,
    output logic           o_empty
);
    import tcf_pkg::*;

    t_work      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full    = r_count == 2'd2;
    assign o_empty   = r_count == 2'd0;
    assign o_rd_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr && !o_full) begin
                r_wptr <= ~r_wptr;
            end
            if (i_rd && !o_empty) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_wr && !o_full) - 2'(i_rd && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/tcf_back.sv =====
// ----------------------------------------------------------------------------
// tcf_back
// iterative cordic, shared-multiplier blend, servo mapping and result buffer
// ----------------------------------------------------------------------------
module tcf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  tcf_pkg::t_work   i_work,
    output logic             o_q_pop,
    input  logic [15:0]      i_weight,
    input  logic [23:0]      i_scale,
    output tcf_pkg::t_result o_result,
    output logic             o_empty,
    input  logic             i_pop
);
    import tcf_pkg::*;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sh7fffffff);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-64'sh80000000);
    localparam logic signed [32:0] ANG_OFS  = 33'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [32:0] ANG_FULL = 33'(180) <<< ANGLE_FRAC_BITS;
    localparam logic [25:0] RECIP9 = 26'd7282;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [ITER_W-1:0] r_iter;
    logic r_axis;

    logic signed [ROT_W-1:0] r_cx [2];
    logic signed [ROT_W-1:0] r_cy [2];
    logic signed [Z_W-1:0]   r_cz [2];
    logic                    r_zero [2];
    logic signed [15:0]      r_g [2];
    logic signed [EST_W-1:0] r_est [2];

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [ESUM_W-1:0] r_esum;

    t_result    r_obuf [2];
    logic       r_owptr;
    logic       r_orptr;
    logic [1:0] r_ocount;

    logic                     start;
    logic                     out_push;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] bsum;
    logic signed [PROD_W-1:0] bsh;
    logic signed [EST_W-1:0]  blended;
    logic signed [Z_W-1:0]    acc_ang;
    logic signed [Z_W-1:0]    a_step;
    t_result                  res;

    assign start    = (r_state == ST_IDLE) && !i_q_empty && (r_ocount != 2'd2);
    assign o_q_pop  = start;
    assign out_push = r_state == ST_OUT;
    assign a_step   = atan_step(ATAN_IDX_W'(r_iter));
    assign acc_ang  = r_zero[r_axis] ? '0 : r_cz[r_axis];

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_ROT;
                end
            end
            ST_ROT: begin
                if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                    n_state = ST_MUL;
                    n_phase = PH_RATE;
                end
            end
            ST_MUL: begin
                unique case (r_phase)
                    PH_RATE:  n_phase = PH_SUM;
                    PH_SUM:   n_phase = PH_GAIN;
                    PH_GAIN:  n_phase = PH_ACCEL;
                    PH_ACCEL: n_phase = PH_BLEND;
                    PH_BLEND: begin
                        n_phase = PH_RATE;
                        if (r_axis) begin
                            n_state = ST_OUT;
                        end
                    end
                    default:  n_phase = PH_RATE;
                endcase
            end
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_phase)
            PH_RATE: begin
                mul_a = MA_W'($signed({1'b0, i_scale}));
                mul_b = MB_W'(r_g[r_axis]);
            end
            PH_GAIN: begin
                mul_a = MA_W'(r_esum);
                mul_b = MB_W'($signed({1'b0, i_weight}));
            end
            PH_ACCEL: begin
                mul_a = MA_W'(acc_ang);
                mul_b = $signed(MB_W'(18'd65536 - {2'b00, i_weight}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = PROD_W'(mul_a * mul_b);
    end

    always_comb begin
        bsum = r_acc + r_prod;
        bsh  = bsum >>> BLEND_SH;
        if (bsh > SAT_HI) begin
            blended = SAT_HI[EST_W-1:0];
        end else if (bsh < SAT_LO) begin
            blended = SAT_LO[EST_W-1:0];
        end else begin
            blended = bsh[EST_W-1:0];
        end
    end

    function automatic logic [7:0] servo(input logic signed [EST_W-1:0] est);
        logic signed [32:0] v;
        v = 33'(est) + ANG_OFS;
        if (v[32]) begin
            return 8'd0;
        end else if (v >= ANG_FULL) begin
            return 8'd180;
        end
        return v[ANGLE_FRAC_BITS+7:ANGLE_FRAC_BITS];
    endfunction

    function automatic logic [10:0] pulse(input logic [7:0] ang);
        logic [25:0] q;
        q = 26'(ang) * 26'd50 * RECIP9;
        return 11'(q[25:16]) + 11'd1000;
    endfunction

    always_comb begin
        res.angle_x = servo(r_est[0]);
        res.angle_y = servo(r_est[1]);
        res.pulse_x = pulse(res.angle_x);
        res.pulse_y = pulse(res.angle_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_RATE;
            r_iter   <= '0;
            r_axis   <= 1'b0;
            r_est[0] <= '0;
            r_est[1] <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (start) begin
                r_iter <= '0;
                r_axis <= 1'b0;
            end else if (r_state == ST_ROT) begin
                r_iter <= r_iter + 1'b1;
            end
            if (r_state == ST_MUL && r_phase == PH_BLEND) begin
                r_est[r_axis] <= blended;
                r_axis        <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_g[0]    <= i_work.g_x;
            r_g[1]    <= i_work.g_y;
            r_zero[0] <= i_work.lane_x.zero;
            r_zero[1] <= i_work.lane_y.zero;
            r_cx[0]   <= {{(ROT_W-33){i_work.lane_x.x0[16]}}, i_work.lane_x.x0, 16'd0};
            r_cy[0]   <= {{(ROT_W-33){i_work.lane_x.y0[16]}}, i_work.lane_x.y0, 16'd0};
            r_cz[0]   <= i_work.lane_x.z0;
            r_cx[1]   <= {{(ROT_W-33){i_work.lane_y.x0[16]}}, i_work.lane_y.x0, 16'd0};
            r_cy[1]   <= {{(ROT_W-33){i_work.lane_y.y0[16]}}, i_work.lane_y.y0, 16'd0};
            r_cz[1]   <= i_work.lane_y.z0;
        end else if (r_state == ST_ROT) begin
            for (int l = 0; l < 2; l++) begin
                if (!r_cy[l][ROT_W-1]) begin
                    r_cx[l] <= r_cx[l] + (r_cy[l] >>> r_iter);
                    r_cy[l] <= r_cy[l] - (r_cx[l] >>> r_iter);
                    r_cz[l] <= r_cz[l] + a_step;
                end else begin
                    r_cx[l] <= r_cx[l] - (r_cy[l] >>> r_iter);
                    r_cy[l] <= r_cy[l] + (r_cx[l] >>> r_iter);
                    r_cz[l] <= r_cz[l] - a_step;
                end
            end
        end
        if (r_state == ST_MUL) begin
            case (r_phase)
                PH_RATE, PH_GAIN: r_prod <= n_prod;
                PH_SUM: r_esum <= ESUM_W'(r_est[r_axis]) + ESUM_W'(r_prod >>> STEP_SH);
                PH_ACCEL: begin
                    r_acc  <= r_prod;
                    r_prod <= n_prod;
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    // result buffer
    assign o_empty  = r_ocount == 2'd0;
    assign o_result = r_obuf[r_orptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owptr  <= 1'b0;
            r_orptr  <= 1'b0;
            r_ocount <= 2'd0;
        end else begin
            if (out_push) begin
                r_owptr <= ~r_owptr;
            end
            if (i_pop && !o_empty) begin
                r_orptr <= ~r_orptr;
            end
            r_ocount <= r_ocount + 2'(out_push) - 2'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_obuf[r_owptr] <= res;
        end
    end

    a_obuf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount != 2'd3)
        else $error("result buffer overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> $past(r_ocount) != 2'd2 || $past(i_pop))
        else $error("result pushed without room");

    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |=> r_state == ST_IDLE)
        else $error("result stage held");

    a_rot_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_MUL) |-> $past(r_iter) == ITER_W'(CORDIC_STEPS - 1))
        else $error("rotation cut short");

endmodule

// ===== rtl/tilt_complementary_filter_servo.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter_servo
// two-axis complementary tilt filter with servo pulse outputs
//
//   channel  handshake                        payload
//   input    push / full                      i_accel_x/y/z, i_rate_x/y
//   result   empty / pop                      o_pulse_x/y, o_servo_angle_x/y
//   config   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// in the back, one item at a time: both cordic lanes rotate together one step a
// cycle, then one shared multiplier runs five steps per axis. a two-word queue
// sits before and after. reset is synchronous, clears both estimates and loads
// the default registers. full rises only when the front queue holds two words;
// the back stalls only when the result buffer holds two words.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_servo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [15:0]                  i_accel_x,
    input  logic signed [15:0]                  i_accel_y,
    input  logic signed [15:0]                  i_accel_z,
    input  logic signed [15:0]                  i_rate_x,
    input  logic signed [15:0]                  i_rate_y,
    output logic                                empty,
    input  logic                                pop,
    output logic [10:0]                         o_pulse_x,
    output logic [10:0]                         o_pulse_y,
    output logic [7:0]                          o_servo_angle_x,
    output logic [7:0]                          o_servo_angle_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tcf_pkg::*;

    logic signed [15:0] r_offset_x;
    logic signed [15:0] r_offset_y;
    logic [15:0]        r_weight;
    logic [23:0]        r_scale;

    t_work   front_work;
    t_work   q_work;
    logic    q_empty;
    logic    q_pop;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= -16'sd239;
            r_offset_y <= 16'sd230;
            r_weight   <= 16'd64225;
            r_scale    <= 24'd12807;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_GYRO_OFFSET_X: r_offset_x <= $signed(i_cfg_data[15:0]);
                CFG_GYRO_OFFSET_Y: r_offset_y <= $signed(i_cfg_data[15:0]);
                CFG_BLEND_WEIGHT:  r_weight   <= i_cfg_data[15:0];
                CFG_GYRO_SCALE:    r_scale    <= i_cfg_data[23:0];
                default:           r_scale    <= r_scale;
            endcase
        end
    end

    tcf_front u_front (
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_rate_x   (i_rate_x),
        .i_rate_y   (i_rate_y),
        .i_offset_x (r_offset_x),
        .i_offset_y (r_offset_y),
        .o_work     (front_work)
    );

    tcf_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_work),
        .o_full    (full),
        .i_rd      (q_pop),
        .o_rd_data (q_work),
        .o_empty   (q_empty)
    );

    tcf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_work    (q_work),
        .o_q_pop   (q_pop),
        .i_weight  (r_weight),
        .i_scale   (r_scale),
        .o_result  (result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    assign o_pulse_x       = result.pulse_x;
    assign o_pulse_y       = result.pulse_y;
    assign o_servo_angle_x = result.angle_x;
    assign o_servo_angle_y = result.angle_y;

endmodule

// ===== tb/tilt_complementary_filter_servo_test.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter_servo_test
// self-checking bench for the two-axis complementary tilt filter: a directed
// table then random imu words under several register settings, each result
// word checked against a bit-exact in-bench model of cordic, blend and servo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_complementary_filter_servo_test;
    import tcf_pkg::*;

    typedef struct {
        logic signed [15:0] ax, ay, az, rx, ry;
        bit                 typed;
        t_result            want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic signed [15:0]    i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic signed [15:0]    i_rate_x = '0, i_rate_y = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [10:0]           o_pulse_x, o_pulse_y;
    logic [7:0]            o_servo_angle_x, o_servo_angle_y;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_GYRO_OFFSET_X;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic signed [15:0] offset_x = -16'sd239, offset_y = 16'sd230;
    logic [15:0]        weight = 16'd64225;
    logic [23:0]        step_scale = 24'd12807;
    logic signed [31:0] tilt_x = '0, tilt_y = '0;

    t_result servo_words[$];
    t_row    rows[13];
    int      errors = 0;
    int      send_idle = 0, pop_idle = 0;

    tilt_complementary_filter_servo uut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic longint accel_angle(longint y, longint x);
        longint z, base, a, xs, ys;
        z = 0;
        base = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            base = (y >= 0) ? (longint'(180) <<< ANGLE_FRAC_BITS)
                            : -(longint'(180) <<< ANGLE_FRAC_BITS);
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            a = (longint'(ATAN_Q24[i]) + (longint'(1) <<< (23 - ANGLE_FRAC_BITS)))
                >>> (24 - ANGLE_FRAC_BITS);
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + a;
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - a;
            end
        end
        return z + base;
    endfunction

    function automatic logic signed [31:0] blend_tilt(logic signed [31:0] est,
            logic signed [15:0] rate, logic signed [15:0] offset, longint acc);
        logic signed [15:0] g;
        longint step, w, r;
        g = rate - offset;
        step = (longint'(g) * longint'(step_scale)) >>> (24 - ANGLE_FRAC_BITS);
        w = longint'(weight);
        r = ((longint'(est) + step) * w + acc * (65536 - w)) >>> 16;
        if (r > 64'sh7fffffff) r = 64'sh7fffffff;
        if (r < -64'sh80000000) r = -64'sh80000000;
        return r[31:0];
    endfunction

    function automatic logic [7:0] servo_deg(logic signed [31:0] est);
        longint v;
        v = longint'(est) + (longint'(90) <<< ANGLE_FRAC_BITS);
        if (v < 0) return 8'd0;
        if (v >= (longint'(180) <<< ANGLE_FRAC_BITS)) return 8'd180;
        return 8'(v >>> ANGLE_FRAC_BITS);
    endfunction

    function automatic t_result track_tilt(logic signed [15:0] ax, ay, az, rx, ry);
        t_result r;
        tilt_x = blend_tilt(tilt_x, rx, offset_x, accel_angle(ay, az));
        tilt_y = blend_tilt(tilt_y, ry, offset_y, accel_angle(ax, az));
        r.angle_x = servo_deg(tilt_x);
        r.angle_y = servo_deg(tilt_y);
        r.pulse_x = 11'(int'(r.angle_x) * 1000 / 180 + 1000);
        r.pulse_y = 11'(int'(r.angle_y) * 1000 / 180 + 1000);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (pop && !empty) begin
            if (servo_words.size() == 0) begin
                report_mismatch("unexpected word", o_pulse_x, 0);
            end else begin
                w = servo_words.pop_front();
                if (o_pulse_x != w.pulse_x) report_mismatch("pulse_x", o_pulse_x, w.pulse_x);
                if (o_pulse_y != w.pulse_y) report_mismatch("pulse_y", o_pulse_y, w.pulse_y);
                if (o_servo_angle_x != w.angle_x)
                    report_mismatch("servo_angle_x", o_servo_angle_x, w.angle_x);
                if (o_servo_angle_y != w.angle_y)
                    report_mismatch("servo_angle_y", o_servo_angle_y, w.angle_y);
            end
        end
        pop <= ($urandom_range(0, 99) >= pop_idle);
    end

    task automatic send_word(t_row r);
        t_result p;
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_accel_x <= r.ax;
        i_accel_y <= r.ay;
        i_accel_z <= r.az;
        i_rate_x <= r.rx;
        i_rate_y <= r.ry;
        do @(posedge i_clk); while (full);
        p = track_tilt(r.ax, r.ay, r.az, r.rx, r.ry);
        servo_words.push_back(r.typed ? r.want : p);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (servo_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GYRO_OFFSET_X: offset_x = data[15:0];
            CFG_GYRO_OFFSET_Y: offset_y = data[15:0];
            CFG_BLEND_WEIGHT:  weight = data[15:0];
            CFG_GYRO_SCALE:    step_scale = data;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_row r;
        rows[0]  = '{0, 0, 0, 0, 0, 1'b1, '{11'd1500, 11'd1494, 8'd90, 8'd89}};
        rows[1]  = '{0, 0, 1, 0, 0, 1'b0, '0};
        rows[2]  = '{0, 0, -1, 0, 0, 1'b0, '0};
        rows[3]  = '{0, -1, -1, 0, 0, 1'b0, '0};
        rows[4]  = '{32767, 32767, 32767, 32767, 32767, 1'b0, '0};
        rows[5]  = '{-32768, -32768, -32768, -32768, -32768, 1'b0, '0};
        rows[6]  = '{-32768, 32767, 0, 0, 0, 1'b0, '0};
        rows[7]  = '{32767, -32768, -32768, 0, 0, 1'b0, '0};
        rows[8]  = '{0, 0, 0, -239, 230, 1'b0, '0};
        rows[9]  = '{1, -1, 32767, -1, 1, 1'b0, '0};
        rows[10] = '{16384, -16384, -32768, 12345, -12345, 1'b0, '0};
        rows[11] = '{-1, -1, -1, -1, -1, 1'b0, '0};
        rows[12] = '{0, 32767, 0, 32767, -32768, 1'b0, '0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 13;
        pop_idle = 84;
        foreach (rows[i]) send_word(rows[i]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_GYRO_OFFSET_X, 24'(-16'sd239));
                    write_reg(CFG_GYRO_OFFSET_Y, 24'd230);
                    write_reg(CFG_BLEND_WEIGHT, 24'd64225);
                    write_reg(CFG_GYRO_SCALE, 24'd12807);
                end
                1: begin
                    write_reg(CFG_GYRO_OFFSET_X, 24'h008000);
                    write_reg(CFG_GYRO_OFFSET_Y, 24'h007fff);
                    write_reg(CFG_BLEND_WEIGHT, 24'd0);
                    write_reg(CFG_GYRO_SCALE, 24'hffffff);
                end
                2: begin
                    write_reg(CFG_GYRO_OFFSET_X, 24'h007fff);
                    write_reg(CFG_GYRO_OFFSET_Y, 24'h008000);
                    write_reg(CFG_BLEND_WEIGHT, 24'hffff);
                    write_reg(CFG_GYRO_SCALE, 24'hffffff);
                end
                3: begin
                    write_reg(CFG_BLEND_WEIGHT, 24'hffff);
                    write_reg(CFG_GYRO_SCALE, 24'd0);
                end
                4: begin
                    write_reg(CFG_GYRO_OFFSET_X, 24'($urandom));
                    write_reg(CFG_GYRO_OFFSET_Y, 24'($urandom));
                    write_reg(CFG_BLEND_WEIGHT, 24'($urandom));
                    write_reg(CFG_GYRO_SCALE, 24'($urandom));
                end
                default: begin
                    write_reg(CFG_GYRO_OFFSET_X, 24'($signed($urandom_range(0, 1000)) - 500));
                    write_reg(CFG_GYRO_OFFSET_Y, 24'($signed($urandom_range(0, 1000)) - 500));
                    write_reg(CFG_BLEND_WEIGHT, 24'($urandom_range(60000, 65535)));
                    write_reg(CFG_GYRO_SCALE, 24'($urandom_range(0, 50000)));
                end
            endcase
            send_idle = (ph < 2) ? 13 : (ph < 4) ? 84 : 0;
            pop_idle = (ph < 2) ? 84 : (ph < 4) ? 13 : 0;
            for (int n = 0; n < 200; n++) begin
                r.ax = pick16();
                r.ay = pick16();
                r.az = pick16();
                r.rx = pick16();
                r.ry = pick16();
                r.typed = 1'b0;
                r.want = '0;
                send_word(r);
            end
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
